/* sv/ier_pkg.sv */
// ============================================================================
// ICMP echo responder package
// Shared types, header offsets, match values and the checksum helper.
// ============================================================================
package ier_pkg;

  localparam int HEADER_BYTES_DEF = 54;
  localparam int COUNT_LIMIT_DEF  = 4095;

  localparam int          CFG_W             = 12;
  localparam logic [11:0] MAX_FRAME_LEN_RST = 12'd1600;

  localparam int         PADDR_W           = 3;
  localparam int         REG_IDX_W         = 1;
  localparam logic [0:0] REG_MAX_FRAME_LEN = 1'b0;

  localparam int PAY_DEPTH = 64;
  localparam int OB_DEPTH  = 4;

  localparam int OFF_DST_MAC   = 0;
  localparam int MAC_LEN       = 6;
  localparam int OFF_ETYPE     = 12;
  localparam int OFF_VER       = 14;
  localparam int OFF_PROTO     = 23;
  localparam int OFF_SRC_IP    = 26;
  localparam int OFF_DST_IP    = 30;
  localparam int IP_LEN        = 4;
  localparam int OFF_ICMP_TYPE = 34;
  localparam int OFF_ICMP_CODE = 35;
  localparam int OFF_ICMP_CSUM = 36;

  localparam logic [7:0] FIRST_BYTE      = 8'h02;
  localparam logic [7:0] ETYPE_HI        = 8'h08;
  localparam logic [7:0] ETYPE_LO        = 8'h00;
  localparam logic [3:0] IPV4_VER        = 4'h4;
  localparam logic [7:0] PROTO_ICMP      = 8'h01;
  localparam logic [7:0] ICMP_ECHO_REQ   = 8'h08;
  localparam logic [7:0] ICMP_ECHO_REPLY = 8'h00;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_last;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       tx_abort;
  } tx_item_t;

  typedef struct packed {
    logic [15:0] csum;
    logic        fin_last;
    logic        fin_abort;
  } desc_t;

  typedef struct packed {
    logic       en;
    logic       bank;
    logic [7:0] data;
  } hdr_wr_t;

  typedef struct packed {
    logic  en;
    logic  bank;
    desc_t desc;
  } desc_wr_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HDR,
    BK_PAY
  } back_state_t;

  function automatic logic [15:0] csum_adjust(logic [15:0] hc, logic [15:0] m_old,
                                              logic [15:0] m_new);
    logic [17:0] s;
    logic [16:0] f1;
    logic [15:0] f2;
    s  = {2'b00, ~hc} + {2'b00, ~m_old} + {2'b00, m_new};
    f1 = {1'b0, s[15:0]} + {15'd0, s[17:16]};
    f2 = f1[15:0] + {15'd0, f1[16]};
    return ~f2;
  endfunction

endpackage

/* sv/ier_queue.sv */
// ============================================================================
// Payload queue
// Memory-based first-word-fall-through queue for pass-through reply beats.
// ============================================================================
module ier_queue #(
  parameter int DEPTH = ier_pkg::PAY_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ier_pkg::tx_item_t push_item,
  output logic              full,
  output logic              head_valid,
  output ier_pkg::tx_item_t head,
  input  logic              pop
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  ier_pkg::tx_item_t mem [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CNTW-1:0]   mem_cnt;
  logic              load;

  assign full = (mem_cnt == CNTW'(DEPTH));
  assign load = (mem_cnt != '0) && (!head_valid || pop);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
    if (load) begin
      head <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      mem_cnt    <= '0;
      head_valid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (load) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      mem_cnt <= mem_cnt + CNTW'(push) - CNTW'(load);
      if (load) begin
        head_valid <= 1'b1;
      end else if (pop) begin
        head_valid <= 1'b0;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("Payload queue written while full.");

endmodule

/* sv/ier_front.sv */
// ============================================================================
// Receive front end
// Counts frame bytes, stores the header, checks for an echo request and
// pushes reply descriptors and pass-through beats toward the back end.
// ============================================================================
module ier_front #(
  parameter int HEADER_BYTES = ier_pkg::HEADER_BYTES_DEF,
  parameter int COUNT_LIMIT  = ier_pkg::COUNT_LIMIT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ier_pkg::CFG_W-1:0]        max_frame_len,
  input  logic                             rx_valid,
  output logic                             rx_ready,
  input  ier_pkg::rx_item_t                rx_data,
  output ier_pkg::hdr_wr_t                 hdr_wr,
  output logic [$clog2(HEADER_BYTES)-1:0]  hdr_idx,
  output ier_pkg::desc_wr_t                desc_wr,
  input  logic [1:0]                       busy,
  output logic                             pay_push,
  output ier_pkg::tx_item_t                pay_item,
  input  logic                             pay_full
);

  localparam int CW = $clog2(COUNT_LIMIT + 1);
  localparam int IW = $clog2(HEADER_BYTES);

  logic [CW-1:0] byte_count;
  logic          answered;
  logic          rejected;
  logic          hdr_ok;
  logic          wbank;
  logic [7:0]    b34, b35, b36, b37;

  logic          acc;
  logic          in_hdr;
  logic          is_decide;
  logic          chk;
  logic          ok_now;
  logic          over_pay;
  logic          over_hdr;
  logic [CW-1:0] cnt_inc;
  logic [7:0]    b;
  logic          last;

  assign b    = rx_data.rx_byte;
  assign last = rx_data.rx_last;

  always_comb begin
    if (rejected) begin
      rx_ready = 1'b1;
    end else if (answered) begin
      rx_ready = !pay_full;
    end else begin
      rx_ready = !busy[wbank];
    end
  end

  assign acc       = rx_valid && rx_ready;
  assign in_hdr    = !answered && !rejected;
  assign is_decide = in_hdr && (byte_count == CW'(HEADER_BYTES - 1));
  assign cnt_inc   = (byte_count < CW'(COUNT_LIMIT)) ? byte_count + CW'(1) : byte_count;
  assign over_pay  = (byte_count >= CW'(COUNT_LIMIT)) ||
                     ({{ier_pkg::CFG_W{1'b0}}, byte_count} >=
                      {{CW{1'b0}}, max_frame_len});
  assign over_hdr  = max_frame_len < ier_pkg::CFG_W'(HEADER_BYTES);

  always_comb begin
    chk = 1'b1;
    if (byte_count == CW'(ier_pkg::OFF_DST_MAC)) begin
      chk = (b == ier_pkg::FIRST_BYTE);
    end else if (byte_count == CW'(ier_pkg::OFF_ETYPE)) begin
      chk = (b == ier_pkg::ETYPE_HI);
    end else if (byte_count == CW'(ier_pkg::OFF_ETYPE + 1)) begin
      chk = (b == ier_pkg::ETYPE_LO);
    end else if (byte_count == CW'(ier_pkg::OFF_VER)) begin
      chk = (b[7:4] == ier_pkg::IPV4_VER);
    end else if (byte_count == CW'(ier_pkg::OFF_PROTO)) begin
      chk = (b == ier_pkg::PROTO_ICMP);
    end else if (byte_count == CW'(ier_pkg::OFF_ICMP_TYPE)) begin
      chk = (b == ier_pkg::ICMP_ECHO_REQ);
    end
  end

  assign ok_now = hdr_ok && chk;

  assign hdr_wr.en   = acc && in_hdr;
  assign hdr_wr.bank = wbank;
  assign hdr_wr.data = b;
  assign hdr_idx     = byte_count[IW-1:0];

  assign desc_wr.en             = acc && is_decide && ok_now;
  assign desc_wr.bank           = wbank;
  assign desc_wr.desc.csum      = ier_pkg::csum_adjust({b36, b37}, {b34, b35},
                                                       {ier_pkg::ICMP_ECHO_REPLY, b35});
  assign desc_wr.desc.fin_last  = last || over_hdr;
  assign desc_wr.desc.fin_abort = over_hdr;

  assign pay_push          = acc && answered && !rejected;
  assign pay_item.tx_byte  = b;
  assign pay_item.tx_last  = last || over_pay;
  assign pay_item.tx_abort = over_pay;

  always_ff @(posedge clk) begin
    if (hdr_wr.en) begin
      if (byte_count == CW'(ier_pkg::OFF_ICMP_TYPE)) begin
        b34 <= b;
      end
      if (byte_count == CW'(ier_pkg::OFF_ICMP_CODE)) begin
        b35 <= b;
      end
      if (byte_count == CW'(ier_pkg::OFF_ICMP_CSUM)) begin
        b36 <= b;
      end
      if (byte_count == CW'(ier_pkg::OFF_ICMP_CSUM + 1)) begin
        b37 <= b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      answered   <= 1'b0;
      rejected   <= 1'b0;
      hdr_ok     <= 1'b1;
      wbank      <= 1'b0;
    end else if (acc) begin
      if (last) begin
        byte_count <= '0;
        answered   <= 1'b0;
        rejected   <= 1'b0;
        hdr_ok     <= 1'b1;
        if (is_decide && ok_now) begin
          wbank <= ~wbank;
        end
      end else if (rejected) begin
        rejected <= 1'b1;
      end else if (answered) begin
        byte_count <= cnt_inc;
        if (over_pay) begin
          answered <= 1'b0;
          rejected <= 1'b1;
        end
      end else begin
        byte_count <= cnt_inc;
        hdr_ok     <= ok_now;
        if (is_decide) begin
          if (!ok_now) begin
            rejected <= 1'b1;
          end else begin
            wbank <= ~wbank;
            if (over_hdr) begin
              rejected <= 1'b1;
            end else begin
              answered <= 1'b1;
            end
          end
        end
      end
    end
  end

  a_bank_free: assert property (@(posedge clk) disable iff (rst)
    hdr_wr.en |-> !busy[hdr_wr.bank])
    else $error("Header bank written while the back end still owns it.");

endmodule

/* sv/ier_back.sv */
// ============================================================================
// Transmit back end
// Replays a stored header with addresses swapped and the ICMP fields
// rewritten, then drains the payload queue, through a small output buffer.
// ============================================================================
module ier_back #(
  parameter int HEADER_BYTES = ier_pkg::HEADER_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ier_pkg::hdr_wr_t                 hdr_wr,
  input  logic [$clog2(HEADER_BYTES)-1:0]  hdr_idx,
  input  ier_pkg::desc_wr_t                desc_wr,
  output logic [1:0]                       busy,
  input  logic                             head_valid,
  input  ier_pkg::tx_item_t                head,
  output logic                             pop,
  output logic                             tx_valid,
  input  logic                             tx_ready,
  output ier_pkg::tx_item_t                tx_data
);

  localparam int IW   = $clog2(HEADER_BYTES);
  localparam int OBAW = $clog2(ier_pkg::OB_DEPTH);
  localparam int OBCW = $clog2(ier_pkg::OB_DEPTH + 1);

  logic [7:0]           hdr_mem [2**(IW+1)];
  logic [7:0]           hdr_q;
  ier_pkg::desc_t       desc_bank [2];

  ier_pkg::back_state_t state, state_next;
  logic                 rbank;
  logic [IW-1:0]        hidx;
  logic [IW-1:0]        src;
  logic                 hdr_issue;
  logic                 hdr_last;
  logic                 issue_ok;

  logic                 s1_valid;
  logic                 s1_pay;
  logic [IW-1:0]        s1_idx;
  ier_pkg::desc_t       s1_desc;
  ier_pkg::tx_item_t    s1_item;
  ier_pkg::tx_item_t    s1_out;

  ier_pkg::tx_item_t    ob [ier_pkg::OB_DEPTH];
  logic [OBAW-1:0]      ob_wr;
  logic [OBAW-1:0]      ob_rd;
  logic [OBCW-1:0]      ob_cnt;
  logic                 tx_pop;

  assign issue_ok = (ob_cnt + OBCW'(s1_valid)) < OBCW'(ier_pkg::OB_DEPTH);
  assign hdr_last = (hidx == IW'(HEADER_BYTES - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ier_pkg::BK_IDLE: begin
        if (busy[rbank]) begin
          state_next = ier_pkg::BK_HDR;
        end
      end
      ier_pkg::BK_HDR: begin
        if (issue_ok && hdr_last) begin
          state_next = desc_bank[rbank].fin_last ? ier_pkg::BK_IDLE : ier_pkg::BK_PAY;
        end
      end
      ier_pkg::BK_PAY: begin
        if (issue_ok && head_valid && head.tx_last) begin
          state_next = ier_pkg::BK_IDLE;
        end
      end
      default: state_next = ier_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    hdr_issue = 1'b0;
    pop       = 1'b0;
    unique case (state)
      ier_pkg::BK_IDLE: ;
      ier_pkg::BK_HDR:  hdr_issue = issue_ok;
      ier_pkg::BK_PAY:  pop = issue_ok && head_valid;
      default: ;
    endcase
  end

  always_comb begin
    src = hidx;
    if (hidx < IW'(ier_pkg::MAC_LEN)) begin
      src = hidx + IW'(ier_pkg::MAC_LEN);
    end else if (hidx < IW'(2 * ier_pkg::MAC_LEN)) begin
      src = hidx - IW'(ier_pkg::MAC_LEN);
    end else if (hidx >= IW'(ier_pkg::OFF_SRC_IP) && hidx < IW'(ier_pkg::OFF_DST_IP)) begin
      src = hidx + IW'(ier_pkg::IP_LEN);
    end else if (hidx >= IW'(ier_pkg::OFF_DST_IP) &&
                 hidx < IW'(ier_pkg::OFF_DST_IP + ier_pkg::IP_LEN)) begin
      src = hidx - IW'(ier_pkg::IP_LEN);
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_wr.en) begin
      hdr_mem[{hdr_wr.bank, hdr_idx}] <= hdr_wr.data;
    end
    hdr_q <= hdr_mem[{rbank, src}];
  end

  always_ff @(posedge clk) begin
    if (desc_wr.en) begin
      desc_bank[desc_wr.bank] <= desc_wr.desc;
    end
    s1_pay  <= pop;
    s1_idx  <= hidx;
    s1_desc <= desc_bank[rbank];
    s1_item <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ier_pkg::BK_IDLE;
      rbank    <= 1'b0;
      hidx     <= '0;
      busy     <= 2'b00;
      s1_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= hdr_issue || pop;
      if (hdr_issue) begin
        if (hdr_last) begin
          hidx  <= '0;
          rbank <= ~rbank;
        end else begin
          hidx <= hidx + IW'(1);
        end
      end
      for (int i = 0; i < 2; i++) begin
        if (desc_wr.en && desc_wr.bank == 1'(i)) begin
          busy[i] <= 1'b1;
        end else if (hdr_issue && hdr_last && rbank == 1'(i)) begin
          busy[i] <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (s1_pay) begin
      s1_out = s1_item;
    end else begin
      s1_out.tx_byte  = hdr_q;
      s1_out.tx_last  = (s1_idx == IW'(HEADER_BYTES - 1)) && s1_desc.fin_last;
      s1_out.tx_abort = (s1_idx == IW'(HEADER_BYTES - 1)) && s1_desc.fin_abort;
      if (s1_idx == IW'(ier_pkg::OFF_ICMP_TYPE)) begin
        s1_out.tx_byte = ier_pkg::ICMP_ECHO_REPLY;
      end else if (s1_idx == IW'(ier_pkg::OFF_ICMP_CSUM)) begin
        s1_out.tx_byte = s1_desc.csum[15:8];
      end else if (s1_idx == IW'(ier_pkg::OFF_ICMP_CSUM + 1)) begin
        s1_out.tx_byte = s1_desc.csum[7:0];
      end
    end
  end

  assign tx_valid = (ob_cnt != '0);
  assign tx_data  = ob[ob_rd];
  assign tx_pop   = tx_valid && tx_ready;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      ob[ob_wr] <= s1_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr  <= '0;
      ob_rd  <= '0;
      ob_cnt <= '0;
    end else begin
      if (s1_valid) begin
        ob_wr <= ob_wr + OBAW'(1);
      end
      if (tx_pop) begin
        ob_rd <= ob_rd + OBAW'(1);
      end
      ob_cnt <= ob_cnt + OBCW'(s1_valid) - OBCW'(tx_pop);
    end
  end

  a_ob_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ob_cnt < OBCW'(ier_pkg::OB_DEPTH))
    else $error("Output buffer written while full.");

  a_read_owned: assert property (@(posedge clk) disable iff (rst)
    hdr_issue |-> busy[rbank])
    else $error("Header replayed from a bank that holds no reply.");

  a_abort_last: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && tx_data.tx_abort) |-> tx_data.tx_last)
    else $error("Abort flagged on a beat that does not end the reply.");

endmodule

/* sv/icmp_echo_responder.sv */
// ============================================================================
// ICMP echo responder
// Answers IPv4 ICMP echo requests carried in Ethernet frames, byte by byte.
// ============================================================================
// One received byte is taken per clock unless input stalls, and, once a
// reply is under way, one reply byte is given per clock while tx_ready is
// high and bytes are at hand. The first 54 bytes of a frame are held in
// one of two header banks; on the 54th byte the frame is checked and, if it
// is an echo request, the rewritten header is replayed from that bank while
// later bytes collect in a 64-beat payload queue. The back end returns to
// idle after each answered frame. Input stalls only when the header bank
// to be written is still being replayed or the payload queue is full. The
// max frame length register sits at byte address 0 of the APB-style port.
module icmp_echo_responder #(
  parameter int HEADER_BYTES = ier_pkg::HEADER_BYTES_DEF,
  parameter int COUNT_LIMIT  = ier_pkg::COUNT_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rx_valid,
  output logic                          rx_ready,
  input  ier_pkg::rx_item_t             rx_data,
  output logic                          tx_valid,
  input  logic                          tx_ready,
  output ier_pkg::tx_item_t             tx_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ier_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int IW = $clog2(HEADER_BYTES);

  logic [ier_pkg::CFG_W-1:0]     max_frame_len;
  logic [ier_pkg::REG_IDX_W-1:0] reg_idx;
  ier_pkg::hdr_wr_t              hdr_wr;
  logic [IW-1:0]                 hdr_idx;
  ier_pkg::desc_wr_t             desc_wr;
  logic [1:0]                    busy;
  logic                          pay_push;
  ier_pkg::tx_item_t             pay_item;
  logic                          pay_full;
  logic                          head_valid;
  ier_pkg::tx_item_t             head;
  logic                          pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ier_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= ier_pkg::MAX_FRAME_LEN_RST;
    end else if (psel && penable && pwrite && pready &&
                 reg_idx == ier_pkg::REG_MAX_FRAME_LEN) begin
      max_frame_len <= pwdata[ier_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      ier_pkg::REG_MAX_FRAME_LEN: prdata = {{(32 - ier_pkg::CFG_W){1'b0}}, max_frame_len};
      default:                    prdata = 32'd0;
    endcase
  end

  ier_front #(
    .HEADER_BYTES (HEADER_BYTES),
    .COUNT_LIMIT  (COUNT_LIMIT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .max_frame_len (max_frame_len),
    .rx_valid      (rx_valid),
    .rx_ready      (rx_ready),
    .rx_data       (rx_data),
    .hdr_wr        (hdr_wr),
    .hdr_idx       (hdr_idx),
    .desc_wr       (desc_wr),
    .busy          (busy),
    .pay_push      (pay_push),
    .pay_item      (pay_item),
    .pay_full      (pay_full)
  );

  ier_queue #(
    .DEPTH (ier_pkg::PAY_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (pay_push),
    .push_item  (pay_item),
    .full       (pay_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  ier_back #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .hdr_wr     (hdr_wr),
    .hdr_idx    (hdr_idx),
    .desc_wr    (desc_wr),
    .busy       (busy),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .tx_valid   (tx_valid),
    .tx_ready   (tx_ready),
    .tx_data    (tx_data)
  );

endmodule
